// ===== design/rpn_pkg.sv =====
`timescale 1ns / 1ps

package rpn_pkg;

    localparam int DATA_W = 32;
    localparam logic [3:0] DIGIT_MAX = 4'd9;

    typedef enum logic [1:0] {
        REQ_DIGIT   = 2'd0,
        REQ_OP      = 2'd1,
        REQ_END     = 2'd2,
        REQ_INVALID = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_ACCEPTED  = 4'd0,
        ST_RESULT    = 4'd1,
        ST_UNDERFLOW = 4'd2,
        ST_OVERFLOW  = 4'd3,
        ST_DIVZERO   = 4'd4,
        ST_INVALID   = 4'd5,
        ST_FULL      = 4'd6,
        ST_BADDEPTH  = 4'd7,
        ST_SKIPPED   = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_X,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_END_RD,
        S_DONE
    } state_t;

    typedef struct packed {
        req_type_t  req_type;
        logic [3:0] digit;
        op_t        operator;
    } rpn_in_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  value;
        logic                      expr_done;
    } rpn_out_t;

endpackage

// ===== design/rpn_ram.sv =====
`timescale 1ns / 1ps

module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rpn_divider.sv =====
`timescale 1ns / 1ps

module rpn_divider (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [rpn_pkg::DATA_W-1:0] dividend,
    input  logic signed [rpn_pkg::DATA_W-1:0] divisor,
    output logic                             done,
    output logic [rpn_pkg::DATA_W-1:0]       quotient
);

    import rpn_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic              neg_reg;

    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;

    assign mag_a     = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
    assign mag_b     = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
    assign rem_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= mag_a;
            dvs_reg <= mag_b;
            neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end else if (busy_reg) begin
            if (!diff[DATA_W]) begin
                rem_reg <= diff[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_shift[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    ap_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

    ap_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");

endmodule

// ===== design/rpn_stack_evaluator_core.sv =====
`timescale 1ns / 1ps

// channel  ports                  payload    direction
// s_       s_valid s_ready s_data rpn_in_t   token items in
// m_       m_valid m_ready m_data rpn_out_t  one result item per token
//
// one token at a time; digit, invalid, skipped and most end tokens go straight to the result
// end with one entry adds a stack read; add and subtract add two stack reads
// multiply adds a registered 32x32 product; divide waits on the
// radix-2 divider, which takes one quotient bit per cycle over 32 steps
// synchronous active-low reset clears depth and error latch; stack memory is not cleared
// a result waiting on m_ready holds the next token out only when the next result is due

module rpn_stack_evaluator_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rpn_pkg::rpn_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rpn_pkg::rpn_out_t m_data
);

    import rpn_pkg::*;

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] MINUS_ONE = '1;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      err_reg, err_next;
    op_t                       op_reg, op_next;
    logic signed [DATA_W-1:0]  y_reg, y_next;
    logic signed [2*DATA_W-1:0] prod_reg, prod_next;
    status_t                   res_status_reg, res_status_next;
    logic [DATA_W-1:0]         res_value_reg, res_value_next;
    logic                      res_done_reg, res_done_next;
    logic                      m_valid_reg, m_valid_next;
    rpn_out_t                  m_data_reg, m_data_next;

    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [DATA_W-1:0]         ram_wdata;
    logic                      ram_re;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [DATA_W-1:0]         ram_rdata;

    logic                      div_start;
    logic                      div_done;
    logic [DATA_W-1:0]         div_quotient;

    logic signed [DATA_W-1:0]  x_val;
    logic [DATA_W:0]           sum;
    logic [DATA_W:0]           dif;
    logic [ADDR_W-1:0]         idx_top;
    logic [ADDR_W-1:0]         idx_below;
    logic                      accept;

    assign x_val     = ram_rdata;
    assign sum       = {x_val[DATA_W-1], x_val} + {y_reg[DATA_W-1], y_reg};
    assign dif       = {x_val[DATA_W-1], x_val} - {y_reg[DATA_W-1], y_reg};
    assign idx_top   = ADDR_W'(count_reg - CNT_W'(1));
    assign idx_below = ADDR_W'(count_reg - CNT_W'(2));
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;

    rpn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rpn_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (x_val),
        .divisor  (y_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        y_reg          <= y_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_done_reg   <= res_done_next;
        m_data_reg     <= m_data_next;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        op_next         = op_reg;
        y_next          = y_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_done_next   = res_done_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_below;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = idx_top;
        div_start       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_value_next = '0;
                    res_done_next  = 1'b0;
                    state_next     = S_DONE;
                    if (s_data.req_type == REQ_END) begin
                        res_done_next = 1'b1;
                        count_next    = '0;
                        err_next      = 1'b0;
                        if (err_reg) begin
                            res_status_next = ST_SKIPPED;
                        end else if (count_reg != CNT_W'(1)) begin
                            res_status_next = ST_BADDEPTH;
                        end else begin
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            state_next = S_END_RD;
                        end
                    end else if (err_reg) begin
                        res_status_next = ST_SKIPPED;
                    end else begin
                        unique case (s_data.req_type)
                            REQ_DIGIT: begin
                                if (s_data.digit > DIGIT_MAX) begin
                                    res_status_next = ST_INVALID;
                                    err_next        = 1'b1;
                                end else if (count_reg >= CNT_W'(STACK_DEPTH)) begin
                                    res_status_next = ST_FULL;
                                    err_next        = 1'b1;
                                end else begin
                                    ram_we          = 1'b1;
                                    ram_waddr       = ADDR_W'(count_reg);
                                    ram_wdata       = DATA_W'(s_data.digit);
                                    count_next      = count_reg + 1'b1;
                                    res_status_next = ST_ACCEPTED;
                                end
                            end
                            REQ_OP: begin
                                if (count_reg < CNT_W'(2)) begin
                                    res_status_next = ST_UNDERFLOW;
                                    err_next        = 1'b1;
                                end else begin
                                    ram_re     = 1'b1;
                                    ram_raddr  = idx_top;
                                    op_next    = s_data.operator;
                                    state_next = S_RD_X;
                                end
                            end
                            default: begin
                                res_status_next = ST_INVALID;
                                err_next        = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_RD_X: begin
                y_next     = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = idx_below;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_DONE;
                unique case (op_reg)
                    OP_ADD, OP_SUB: begin
                        if ((op_reg == OP_ADD && sum[DATA_W] != sum[DATA_W-1]) ||
                            (op_reg == OP_SUB && dif[DATA_W] != dif[DATA_W-1])) begin
                            res_status_next = ST_OVERFLOW;
                            err_next        = 1'b1;
                        end else begin
                            ram_we          = 1'b1;
                            ram_wdata       = (op_reg == OP_ADD) ? sum[DATA_W-1:0]
                                                                 : dif[DATA_W-1:0];
                            count_next      = count_reg - 1'b1;
                            res_status_next = ST_ACCEPTED;
                        end
                    end
                    OP_MUL: begin
                        prod_next  = (2*DATA_W)'(x_val) * (2*DATA_W)'(y_reg);
                        state_next = S_MUL;
                    end
                    OP_DIV: begin
                        if (y_reg == '0) begin
                            res_status_next = ST_DIVZERO;
                            err_next        = 1'b1;
                        end else if (x_val == INT_MIN && y_reg == MINUS_ONE) begin
                            res_status_next = ST_OVERFLOW;
                            err_next        = 1'b1;
                        end else begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                endcase
            end
            S_MUL: begin
                state_next = S_DONE;
                if (prod_reg[2*DATA_W-1:DATA_W] != {DATA_W{prod_reg[DATA_W-1]}}) begin
                    res_status_next = ST_OVERFLOW;
                    err_next        = 1'b1;
                end else begin
                    ram_we          = 1'b1;
                    ram_wdata       = prod_reg[DATA_W-1:0];
                    count_next      = count_reg - 1'b1;
                    res_status_next = ST_ACCEPTED;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    ram_we          = 1'b1;
                    ram_wdata       = div_quotient;
                    count_next      = count_reg - 1'b1;
                    res_status_next = ST_ACCEPTED;
                    state_next      = S_DONE;
                end
            end
            S_END_RD: begin
                res_status_next = ST_RESULT;
                res_value_next  = ram_rdata;
                state_next      = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.status    = res_status_reg;
                    m_data_next.value     = res_value_reg;
                    m_data_next.expr_done = res_done_reg;
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    ap_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack depth beyond bound");

    ap_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.req_type == REQ_END) |=> (count_reg == '0 && !err_reg))
        else $error("end token left stack state behind");

    ap_no_write_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !err_reg)
        else $error("stack written while error latched");

    ap_result_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_RESULT) |-> m_data.expr_done)
        else $error("result item without end flag");

    ap_div_only_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside a divide");

endmodule
